// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge of clk, reset cycles included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rpt_pkg.sv =====
package rpt_pkg;

  localparam int CNT_W   = 16;
  localparam int PRESC_W = 15;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  localparam logic [1:0] SLEEP_STANDBY   = 2'd2;
  localparam logic [1:0] SLEEP_POWERDOWN = 2'd3;

  // Register offsets
  localparam logic [4:0] OFS_CTRLA       = 5'h00;
  localparam logic [4:0] OFS_STATUS      = 5'h01;
  localparam logic [4:0] OFS_INTCTRL     = 5'h02;
  localparam logic [4:0] OFS_INTFLAGS    = 5'h03;
  localparam logic [4:0] OFS_TEMP        = 5'h04;
  localparam logic [4:0] OFS_DBGCTRL     = 5'h05;
  localparam logic [4:0] OFS_CALIB       = 5'h06;
  localparam logic [4:0] OFS_CLKSEL      = 5'h07;
  localparam logic [4:0] OFS_CNTL        = 5'h08;
  localparam logic [4:0] OFS_CNTH        = 5'h09;
  localparam logic [4:0] OFS_PERL        = 5'h0A;
  localparam logic [4:0] OFS_PERH        = 5'h0B;
  localparam logic [4:0] OFS_CMPL        = 5'h0C;
  localparam logic [4:0] OFS_CMPH        = 5'h0D;
  localparam logic [4:0] OFS_PITCTRLA    = 5'h10;
  localparam logic [4:0] OFS_PITSTATUS   = 5'h11;
  localparam logic [4:0] OFS_PITINTCTRL  = 5'h12;
  localparam logic [4:0] OFS_PITINTFLAGS = 5'h13;

  localparam logic [7:0] CTRLA_WMASK    = 8'hFD;
  localparam logic [7:0] PITCTRLA_WMASK = 8'h79;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
    logic [1:0] sleep_mode;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rtc_irq;
    logic       pit_irq;
  } result_t;

endpackage

// ===== rtl/rpt_in_stage.sv =====
module rpt_in_stage
  import rpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  valid,
  output item_t item
);

  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/rpt_core.sv =====
module rpt_core
  import rpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic [7:0]         control_a, control_a_next;
  logic [1:0]         int_enables, int_enables_next;
  logic [1:0]         int_flags, int_flags_next;
  logic [7:0]         temp_byte, temp_byte_next;
  logic [7:0]         calib_byte, calib_byte_next;
  logic [1:0]         clock_select, clock_select_next;
  logic [CNT_W-1:0]   rtc_count, rtc_count_next;
  logic [CNT_W-1:0]   period_value, period_value_next;
  logic [CNT_W-1:0]   compare_value, compare_value_next;
  logic [7:0]         pit_control, pit_control_next;
  logic               pit_enable_bit, pit_enable_bit_next;
  logic               pit_flag, pit_flag_next;
  logic [15:0]        pit_count, pit_count_next;
  logic [PRESC_W-1:0] prescale_count, prescale_count_next;

  logic [7:0]         rd;
  logic [CNT_W-1:0]   word;
  logic [3:0]         psel;
  logic [3:0]         period;
  logic               paused;
  logic               rtc_run;
  logic               pit_run;
  logic [PRESC_W-1:0] presc_inc;
  logic [PRESC_W-1:0] presc_mask;
  logic [15:0]        pit_top;

  assign word       = CNT_W'({item.write_data, temp_byte});
  assign psel       = control_a[6:3];
  assign period     = pit_control[6:3];
  assign paused     = (item.sleep_mode == SLEEP_POWERDOWN) ||
                      ((item.sleep_mode == SLEEP_STANDBY) && !control_a[7]);
  assign rtc_run    = control_a[0] && !paused;
  assign pit_run    = pit_control[0] && (period != 4'd0);
  assign presc_inc  = prescale_count + PRESC_W'(1);
  assign presc_mask = PRESC_W'((16'd1 << psel) - 16'd1);
  assign pit_top    = 16'hFFFF >> (4'd15 - period);

  always_comb begin
    control_a_next      = control_a;
    int_enables_next    = int_enables;
    int_flags_next      = int_flags;
    temp_byte_next      = temp_byte;
    calib_byte_next     = calib_byte;
    clock_select_next   = clock_select;
    rtc_count_next      = rtc_count;
    period_value_next   = period_value;
    compare_value_next  = compare_value;
    pit_control_next    = pit_control;
    pit_enable_bit_next = pit_enable_bit;
    pit_flag_next       = pit_flag;
    pit_count_next      = pit_count;
    prescale_count_next = prescale_count;
    rd                  = 8'd0;

    unique case (item.opcode)
      OP_READ: begin
        unique case (item.reg_offset)
          OFS_CTRLA:       rd = control_a;
          OFS_INTCTRL:     rd = {6'd0, int_enables};
          OFS_INTFLAGS:    rd = {6'd0, int_flags};
          OFS_TEMP:        rd = temp_byte;
          OFS_CALIB:       rd = calib_byte;
          OFS_CLKSEL:      rd = {6'd0, clock_select};
          OFS_CNTL: begin
            rd             = rtc_count[7:0];
            temp_byte_next = 8'(rtc_count >> 8);
          end
          OFS_PERL: begin
            rd             = period_value[7:0];
            temp_byte_next = 8'(period_value >> 8);
          end
          OFS_CMPL: begin
            rd             = compare_value[7:0];
            temp_byte_next = 8'(compare_value >> 8);
          end
          OFS_CNTH, OFS_PERH, OFS_CMPH: rd = temp_byte;
          OFS_PITCTRLA:    rd = pit_control;
          OFS_PITINTCTRL:  rd = {7'd0, pit_enable_bit};
          OFS_PITINTFLAGS: rd = {7'd0, pit_flag};
          default:         rd = 8'd0;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_offset)
          OFS_CTRLA:    control_a_next = item.write_data & CTRLA_WMASK;
          OFS_INTCTRL:  int_enables_next = item.write_data[1:0];
          OFS_INTFLAGS: int_flags_next = int_flags & ~item.write_data[1:0];
          OFS_TEMP, OFS_CNTL, OFS_PERL, OFS_CMPL: temp_byte_next = item.write_data;
          OFS_CALIB:    calib_byte_next = item.write_data;
          OFS_CLKSEL:   clock_select_next = item.write_data[1:0];
          OFS_CNTH:     rtc_count_next = word;
          OFS_PERH:     period_value_next = word;
          OFS_CMPH:     compare_value_next = word;
          OFS_PITCTRLA: pit_control_next = item.write_data & PITCTRLA_WMASK;
          OFS_PITINTCTRL: pit_enable_bit_next = item.write_data[0];
          OFS_PITINTFLAGS: begin
            if (item.write_data[0]) begin
              pit_flag_next = 1'b0;
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (!control_a[0] && !pit_run) begin
          prescale_count_next = '0;
        end else begin
          prescale_count_next = presc_inc;
          if ((presc_inc & presc_mask) == '0) begin
            if (rtc_run) begin
              if (rtc_count >= period_value) begin
                rtc_count_next    = '0;
                int_flags_next[0] = 1'b1;
              end else begin
                rtc_count_next = rtc_count + CNT_W'(1);
              end
              if (rtc_count_next == compare_value) begin
                int_flags_next[1] = 1'b1;
              end
            end
            if (pit_run) begin
              if (pit_count >= pit_top) begin
                pit_count_next = '0;
                pit_flag_next  = 1'b1;
              end else begin
                pit_count_next = pit_count + 16'd1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign res.read_data = rd;
  assign res.rtc_irq   = |(int_flags_next & int_enables_next);
  assign res.pit_irq   = pit_flag_next & pit_enable_bit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_a      <= '0;
      int_enables    <= '0;
      int_flags      <= '0;
      temp_byte      <= '0;
      calib_byte     <= '0;
      clock_select   <= '0;
      rtc_count      <= '0;
      period_value   <= '1;
      compare_value  <= '0;
      pit_control    <= '0;
      pit_enable_bit <= 1'b0;
      pit_flag       <= 1'b0;
      pit_count      <= '0;
      prescale_count <= '0;
    end else if (fire) begin
      control_a      <= control_a_next;
      int_enables    <= int_enables_next;
      int_flags      <= int_flags_next;
      temp_byte      <= temp_byte_next;
      calib_byte     <= calib_byte_next;
      clock_select   <= clock_select_next;
      rtc_count      <= rtc_count_next;
      period_value   <= period_value_next;
      compare_value  <= compare_value_next;
      pit_control    <= pit_control_next;
      pit_enable_bit <= pit_enable_bit_next;
      pit_flag       <= pit_flag_next;
      pit_count      <= pit_count_next;
      prescale_count <= prescale_count_next;
    end
  end

endmodule

// ===== rtl/rpt_out_stage.sv =====
module rpt_out_stage
  import rpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

// ===== rtl/rtc_pit_timer_peripheral_core.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------------
// in       | in_valid, in_ready  | opcode, reg_offset, write_data, sleep_mode
// out      | out_valid, out_ready| read_data, rtc_irq, pit_irq
//
// Every request yields one result via the input register and then the result register.
// One request is accepted per cycle while in_ready is high; the register update and the
// result of a request are combinational between the input and the result register.
// rst (synchronous, active high) resets control state and valid flags; PER gets all ones.
// in_ready drops only while a result sits in the output register with out_ready low.
module rtc_pit_timer_peripheral_core
  import rpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [4:0] reg_offset,
  input  logic [7:0] write_data,
  input  logic [1:0] sleep_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       rtc_irq,
  output logic       pit_irq
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    out_free;
  logic    fire;
  result_t core_res;
  result_t out_res;

  // Pack the request fields for the input register.
  assign in_item.opcode     = opcode;
  assign in_item.reg_offset = reg_offset;
  assign in_item.write_data = write_data;
  assign in_item.sleep_mode = sleep_mode;

  // Process the held request whenever the result register can take its result.
  assign fire = s1_valid && out_free;

  rpt_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (out_free),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  // Register file, prescaler, RTC and PIT counters; updates only on fire or rst.
  rpt_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (s1_item),
    .res  (core_res)
  );

  rpt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (core_res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (out_res)
  );

  assign read_data = out_res.read_data;
  assign rtc_irq   = out_res.rtc_irq;
  assign pit_irq   = out_res.pit_irq;

endmodule

// ===== rtl/rpt_checker.sv =====
`include "assert_macros.svh"

module rpt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       rtc_irq,
  input logic       pit_irq
);

  logic [9:0] res_bits;

  assign res_bits = {read_data, rtc_irq, pit_irq};

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped in stall")
  `ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(res_bits), "payload changed")
  `ASSERT_CLK(a_stall_cause, !in_ready |-> out_valid && !out_ready, "stall without back-pressure")
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !out_valid, "result presented right after reset")

endmodule

bind rtc_pit_timer_peripheral_core rpt_checker u_rpt_checker (.*);
